@@ hw/rtl/hpq_pkg.sv @@
// Shared types, widths and microcode encodings for the heap priority queue.
// No dependencies; all other files reference this package by scoped names.
package hpq_pkg;

  localparam int CAPACITY = 1024;
  localparam int IDX_W    = $clog2(CAPACITY);      // heap position
  localparam int FILL_W   = $clog2(CAPACITY + 1);  // entry count, holds CAPACITY itself
  localparam int KID_W    = IDX_W + 2;             // 2*pos+2 without overflow
  localparam int COUNT_W  = 11;                    // reported entry count
  localparam int STEP_W   = 4;

  typedef struct packed {
    logic signed [31:0] score;
    logic        [15:0] row;
    logic        [15:0] column;
  } entry_t;

  // status codes
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // func codes
  localparam logic FN_INSERT = 1'b0;
  localparam logic FN_REMOVE = 1'b1;

  // microprogram step addresses
  localparam logic [STEP_W-1:0] S_IDLE      = 4'd0;
  localparam logic [STEP_W-1:0] S_INS_READ  = 4'd1;
  localparam logic [STEP_W-1:0] S_INS_TEST  = 4'd2;
  localparam logic [STEP_W-1:0] S_INS_MOVE  = 4'd3;
  localparam logic [STEP_W-1:0] S_INS_PUT   = 4'd4;
  localparam logic [STEP_W-1:0] S_REM_LOAD  = 4'd5;
  localparam logic [STEP_W-1:0] S_REM_TAKE  = 4'd6;
  localparam logic [STEP_W-1:0] S_REM_LEFT  = 4'd7;
  localparam logic [STEP_W-1:0] S_REM_RIGHT = 4'd8;
  localparam logic [STEP_W-1:0] S_REM_PICK  = 4'd9;
  localparam logic [STEP_W-1:0] S_REM_TEST  = 4'd10;
  localparam logic [STEP_W-1:0] S_REM_MOVE  = 4'd11;
  localparam logic [STEP_W-1:0] S_REM_PUT   = 4'd12;
  localparam logic [STEP_W-1:0] S_REJ_FULL  = 4'd13;
  localparam logic [STEP_W-1:0] S_REJ_EMPTY = 4'd14;

  // memory read address select
  localparam logic [2:0] RD_NONE   = 3'd0;
  localparam logic [2:0] RD_PARENT = 3'd1;
  localparam logic [2:0] RD_LCHILD = 3'd2;
  localparam logic [2:0] RD_RCHILD = 3'd3;
  localparam logic [2:0] RD_LAST   = 3'd4;

  // memory write data select (address is always pos)
  localparam logic [1:0] WR_NONE  = 2'd0;
  localparam logic [1:0] WR_CUR   = 2'd1;
  localparam logic [1:0] WR_RDATA = 2'd2;
  localparam logic [1:0] WR_BEST  = 2'd3;

  localparam logic [1:0] CUR_HOLD  = 2'd0;
  localparam logic [1:0] CUR_IN    = 2'd1;
  localparam logic [1:0] CUR_RDATA = 2'd2;

  localparam logic [2:0] POS_HOLD   = 3'd0;
  localparam logic [2:0] POS_FILL   = 3'd1;
  localparam logic [2:0] POS_ZERO   = 3'd2;
  localparam logic [2:0] POS_PARENT = 3'd3;
  localparam logic [2:0] POS_BEST   = 3'd4;

  localparam logic [1:0] BEST_HOLD  = 2'd0;
  localparam logic [1:0] BEST_LEFT  = 2'd1;
  localparam logic [1:0] BEST_RIGHT = 2'd2;  // take right child only if strictly larger

  localparam logic [1:0] FILL_HOLD = 2'd0;
  localparam logic [1:0] FILL_INC  = 2'd1;
  localparam logic [1:0] FILL_DEC  = 2'd2;

  localparam logic [2:0] J_NEXT     = 3'd0;
  localparam logic [2:0] J_GOTO     = 3'd1;
  localparam logic [2:0] J_IF       = 3'd2;
  localparam logic [2:0] J_DISPATCH = 3'd3;
  localparam logic [2:0] J_END      = 3'd4;

  localparam logic [2:0] C_POS_ZERO  = 3'd0;
  localparam logic [2:0] C_PARENT_GT = 3'd1;
  localparam logic [2:0] C_NO_CHILD  = 3'd2;
  localparam logic [2:0] C_NO_RIGHT  = 3'd3;
  localparam logic [2:0] C_STOP      = 3'd4;

  typedef struct packed {
    logic [2:0]        rd;
    logic [1:0]        wr;
    logic [1:0]        cur_ld;
    logic [2:0]        pos_ld;
    logic [1:0]        best_ld;
    logic [1:0]        fill_op;
    logic [2:0]        jmp;
    logic [2:0]        cond;
    logic [STEP_W-1:0] target;
    logic [1:0]        st;
  } ucw_t;

  // datapath condition flags seen by the sequencer
  typedef struct packed {
    logic pos_zero;
    logic parent_gt;
    logic no_child;
    logic no_right;
    logic stop;
    logic full;
    logic empty;
  } flags_t;

endpackage

@@ hw/rtl/max_heap_priority_queue_top.sv @@
// Binary max-heap priority queue: 1024 entries of {score, row, column}.
//
// Command channel: a transaction is accepted on a rising edge with start high
// and busy low. func selects insert (score, row, column are taken) or remove
// of the top entry (payload ignored). busy stays high until the result.
// Result channel: done pulses for one cycle; status, top_valid, top_score,
// top_row, top_column and entry_count are valid in that cycle. The receiver
// cannot stall the block; each transaction yields exactly one result.
//
// Timing is set by the microcode sequencer and the entry memory (one registered
// read per step). An insert reads the parent, tests and moves once per level
// climbed (at most 9 levels), then puts the entry; a remove loads the last entry,
// then per level (at most 9) reads the children, picks, tests and moves, then puts
// the entry. A rejected insert (full) or remove (empty) ends without touching the
// heap. A new command is taken in the cycle the result strobe is shown.
//
// Reset (rst, synchronous) empties the heap and idles the sequencer; the
// entry memory itself is not cleared, only the fill count.
// Depends on hpq_pkg, hpq_seq, hpq_datapath.
module max_heap_priority_queue_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic                        func,
  input  logic signed [31:0]          score,
  input  logic        [15:0]          row,
  input  logic        [15:0]          column,
  output logic                        done,
  output logic        [1:0]           status,
  output logic                        top_valid,
  output logic signed [31:0]          top_score,
  output logic        [15:0]          top_row,
  output logic        [15:0]          top_column,
  output logic [hpq_pkg::COUNT_W-1:0] entry_count
);

  hpq_pkg::ucw_t             cw;
  hpq_pkg::flags_t           flags;
  hpq_pkg::entry_t           in_entry;
  hpq_pkg::entry_t           root;
  logic [hpq_pkg::FILL_W-1:0] fill;

  assign in_entry.score  = score;
  assign in_entry.row    = row;
  assign in_entry.column = column;

  hpq_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .func   (func),
    .flags  (flags),
    .cw     (cw),
    .busy   (busy),
    .done   (done),
    .status (status)
  );

  hpq_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .cw       (cw),
    .in_entry (in_entry),
    .flags    (flags),
    .root     (root),
    .fill     (fill)
  );

  assign top_valid   = (fill != '0);
  assign top_score   = top_valid ? root.score  : '0;
  assign top_row     = top_valid ? root.row    : '0;
  assign top_column  = top_valid ? root.column : '0;
  assign entry_count = hpq_pkg::COUNT_W'(fill);

endmodule

@@ hw/rtl/hpq_ucode_rom.sv @@
// Microcode ROM for the heap priority queue: one control word per step.
// Depends on hpq_pkg.
module hpq_ucode_rom (
  input  logic [hpq_pkg::STEP_W-1:0] step,
  output hpq_pkg::ucw_t              cw
);

  always_comb begin
    cw         = '0;
    cw.rd      = hpq_pkg::RD_NONE;
    cw.wr      = hpq_pkg::WR_NONE;
    cw.cur_ld  = hpq_pkg::CUR_HOLD;
    cw.pos_ld  = hpq_pkg::POS_HOLD;
    cw.best_ld = hpq_pkg::BEST_HOLD;
    cw.fill_op = hpq_pkg::FILL_HOLD;
    cw.jmp     = hpq_pkg::J_NEXT;
    cw.cond    = hpq_pkg::C_POS_ZERO;
    cw.target  = hpq_pkg::S_IDLE;
    cw.st      = hpq_pkg::ST_DONE;
    case (step)
      hpq_pkg::S_IDLE: begin
        // capture the incoming entry every idle cycle; tail position for insert
        cw.cur_ld = hpq_pkg::CUR_IN;
        cw.pos_ld = hpq_pkg::POS_FILL;
        cw.jmp    = hpq_pkg::J_DISPATCH;
      end
      hpq_pkg::S_INS_READ: begin
        cw.rd     = hpq_pkg::RD_PARENT;
        cw.jmp    = hpq_pkg::J_IF;
        cw.cond   = hpq_pkg::C_POS_ZERO;
        cw.target = hpq_pkg::S_INS_PUT;
      end
      hpq_pkg::S_INS_TEST: begin
        cw.jmp    = hpq_pkg::J_IF;
        cw.cond   = hpq_pkg::C_PARENT_GT;
        cw.target = hpq_pkg::S_INS_PUT;
      end
      hpq_pkg::S_INS_MOVE: begin
        cw.wr     = hpq_pkg::WR_RDATA;
        cw.pos_ld = hpq_pkg::POS_PARENT;
        cw.jmp    = hpq_pkg::J_GOTO;
        cw.target = hpq_pkg::S_INS_READ;
      end
      hpq_pkg::S_INS_PUT: begin
        cw.wr      = hpq_pkg::WR_CUR;
        cw.fill_op = hpq_pkg::FILL_INC;
        cw.jmp     = hpq_pkg::J_END;
        cw.st      = hpq_pkg::ST_DONE;
      end
      hpq_pkg::S_REM_LOAD: begin
        cw.rd      = hpq_pkg::RD_LAST;
        cw.fill_op = hpq_pkg::FILL_DEC;
        cw.pos_ld  = hpq_pkg::POS_ZERO;
      end
      hpq_pkg::S_REM_TAKE: begin
        cw.cur_ld = hpq_pkg::CUR_RDATA;
      end
      hpq_pkg::S_REM_LEFT: begin
        cw.rd     = hpq_pkg::RD_LCHILD;
        cw.jmp    = hpq_pkg::J_IF;
        cw.cond   = hpq_pkg::C_NO_CHILD;
        cw.target = hpq_pkg::S_REM_PUT;
      end
      hpq_pkg::S_REM_RIGHT: begin
        cw.best_ld = hpq_pkg::BEST_LEFT;
        cw.rd      = hpq_pkg::RD_RCHILD;
        cw.jmp     = hpq_pkg::J_IF;
        cw.cond    = hpq_pkg::C_NO_RIGHT;
        cw.target  = hpq_pkg::S_REM_TEST;
      end
      hpq_pkg::S_REM_PICK: begin
        cw.best_ld = hpq_pkg::BEST_RIGHT;
      end
      hpq_pkg::S_REM_TEST: begin
        cw.jmp    = hpq_pkg::J_IF;
        cw.cond   = hpq_pkg::C_STOP;
        cw.target = hpq_pkg::S_REM_PUT;
      end
      hpq_pkg::S_REM_MOVE: begin
        cw.wr     = hpq_pkg::WR_BEST;
        cw.pos_ld = hpq_pkg::POS_BEST;
        cw.jmp    = hpq_pkg::J_GOTO;
        cw.target = hpq_pkg::S_REM_LEFT;
      end
      hpq_pkg::S_REM_PUT: begin
        cw.wr  = hpq_pkg::WR_CUR;
        cw.jmp = hpq_pkg::J_END;
        cw.st  = hpq_pkg::ST_DONE;
      end
      hpq_pkg::S_REJ_FULL: begin
        cw.jmp = hpq_pkg::J_END;
        cw.st  = hpq_pkg::ST_FULL;
      end
      hpq_pkg::S_REJ_EMPTY: begin
        cw.jmp = hpq_pkg::J_END;
        cw.st  = hpq_pkg::ST_EMPTY;
      end
      default: begin
        cw.jmp    = hpq_pkg::J_GOTO;
        cw.target = hpq_pkg::S_IDLE;
      end
    endcase
  end

endmodule

@@ hw/rtl/hpq_seq.sv @@
// Microcode sequencer: step counter, jump logic, result strobe and status.
// Depends on hpq_pkg and hpq_ucode_rom.
module hpq_seq (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 func,
  input  hpq_pkg::flags_t      flags,
  output hpq_pkg::ucw_t        cw,
  output logic                 busy,
  output logic                 done,
  output logic [1:0]           status
);

  logic [hpq_pkg::STEP_W-1:0] step;
  logic [hpq_pkg::STEP_W-1:0] step_next;
  logic                       cond_hit;

  hpq_ucode_rom u_rom (
    .step (step),
    .cw   (cw)
  );

  always_comb begin
    case (cw.cond)
      hpq_pkg::C_POS_ZERO:  cond_hit = flags.pos_zero;
      hpq_pkg::C_PARENT_GT: cond_hit = flags.parent_gt;
      hpq_pkg::C_NO_CHILD:  cond_hit = flags.no_child;
      hpq_pkg::C_NO_RIGHT:  cond_hit = flags.no_right;
      hpq_pkg::C_STOP:      cond_hit = flags.stop;
      default:              cond_hit = 1'b0;
    endcase
  end

  always_comb begin
    case (cw.jmp)
      hpq_pkg::J_NEXT: step_next = step + 1'b1;
      hpq_pkg::J_GOTO: step_next = cw.target;
      hpq_pkg::J_IF:   step_next = cond_hit ? cw.target : step + 1'b1;
      hpq_pkg::J_DISPATCH: begin
        if (!start) begin
          step_next = hpq_pkg::S_IDLE;
        end else if (func == hpq_pkg::FN_INSERT) begin
          step_next = flags.full ? hpq_pkg::S_REJ_FULL : hpq_pkg::S_INS_READ;
        end else begin
          step_next = flags.empty ? hpq_pkg::S_REJ_EMPTY : hpq_pkg::S_REM_LOAD;
        end
      end
      default: step_next = hpq_pkg::S_IDLE;  // end of program
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= hpq_pkg::S_IDLE;
      done <= 1'b0;
    end else begin
      step <= step_next;
      done <= (cw.jmp == hpq_pkg::J_END);
    end
  end

  always_ff @(posedge clk) begin
    if (cw.jmp == hpq_pkg::J_END) begin
      status <= cw.st;
    end
  end

  assign busy = (step != hpq_pkg::S_IDLE);

`ifndef ASSERT_OFF
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> (step == hpq_pkg::S_IDLE))
    else $error("result strobe while program still running");
  a_start_runs: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not start the program");
  a_done_once: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");
`endif

endmodule

@@ hw/rtl/hpq_datapath.sv @@
// Heap datapath: entry memory, moving/best entry registers, position and fill count.
// Depends on hpq_pkg; driven by the control word from hpq_seq.
module hpq_datapath (
  input  logic                         clk,
  input  logic                         rst,
  input  hpq_pkg::ucw_t                cw,
  input  hpq_pkg::entry_t              in_entry,
  output hpq_pkg::flags_t              flags,
  output hpq_pkg::entry_t              root,
  output logic [hpq_pkg::FILL_W-1:0]   fill
);

  hpq_pkg::entry_t mem [hpq_pkg::CAPACITY];
  hpq_pkg::entry_t rdata;
  hpq_pkg::entry_t cur;
  hpq_pkg::entry_t best;
  hpq_pkg::entry_t wdata;

  logic [hpq_pkg::IDX_W-1:0]  pos;
  logic [hpq_pkg::IDX_W-1:0]  pos_m1;
  logic [hpq_pkg::IDX_W-1:0]  parent;
  logic [hpq_pkg::IDX_W-1:0]  best_idx;
  logic [hpq_pkg::IDX_W-1:0]  raddr;
  logic [hpq_pkg::FILL_W-1:0] fill_m1;
  logic [hpq_pkg::KID_W-1:0]  lchild;
  logic [hpq_pkg::KID_W-1:0]  rchild;
  logic [hpq_pkg::KID_W-1:0]  fill_x;
  logic                       rd_en;
  logic                       we;

  assign pos_m1  = pos - 1'b1;
  assign parent  = {1'b0, pos_m1[hpq_pkg::IDX_W-1:1]};
  assign lchild  = {1'b0, pos, 1'b1};
  assign rchild  = lchild + 1'b1;
  assign fill_x  = hpq_pkg::KID_W'(fill);
  assign fill_m1 = fill - 1'b1;

  always_comb begin
    rd_en = 1'b1;
    case (cw.rd)
      hpq_pkg::RD_PARENT: raddr = parent;
      hpq_pkg::RD_LCHILD: raddr = lchild[hpq_pkg::IDX_W-1:0];
      hpq_pkg::RD_RCHILD: raddr = rchild[hpq_pkg::IDX_W-1:0];
      hpq_pkg::RD_LAST:   raddr = fill_m1[hpq_pkg::IDX_W-1:0];
      default: begin
        raddr = '0;
        rd_en = 1'b0;
      end
    endcase
  end

  always_comb begin
    we = 1'b1;
    case (cw.wr)
      hpq_pkg::WR_CUR:   wdata = cur;
      hpq_pkg::WR_RDATA: wdata = rdata;
      hpq_pkg::WR_BEST:  wdata = best;
      default: begin
        wdata = cur;
        we    = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[pos] <= wdata;
    end
    if (rd_en) begin
      rdata <= mem[raddr];
    end
  end

  // root copy kept in step with every write to position zero
  always_ff @(posedge clk) begin
    if (we && pos == '0) begin
      root <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    case (cw.cur_ld)
      hpq_pkg::CUR_IN:    cur <= in_entry;
      hpq_pkg::CUR_RDATA: cur <= rdata;
      default:            cur <= cur;
    endcase

    case (cw.pos_ld)
      hpq_pkg::POS_FILL:   pos <= fill[hpq_pkg::IDX_W-1:0];
      hpq_pkg::POS_ZERO:   pos <= '0;
      hpq_pkg::POS_PARENT: pos <= parent;
      hpq_pkg::POS_BEST:   pos <= best_idx;
      default:             pos <= pos;
    endcase

    case (cw.best_ld)
      hpq_pkg::BEST_LEFT: begin
        best     <= rdata;
        best_idx <= lchild[hpq_pkg::IDX_W-1:0];
      end
      hpq_pkg::BEST_RIGHT: begin
        if (best.score < rdata.score) begin
          best     <= rdata;
          best_idx <= rchild[hpq_pkg::IDX_W-1:0];
        end
      end
      default: begin
        best     <= best;
        best_idx <= best_idx;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else begin
      case (cw.fill_op)
        hpq_pkg::FILL_INC: fill <= fill + 1'b1;
        hpq_pkg::FILL_DEC: fill <= fill_m1;
        default:           fill <= fill;
      endcase
    end
  end

  always_comb begin
    flags.pos_zero  = (pos == '0);
    // new entry rises over a parent of equal score
    flags.parent_gt = (rdata.score > cur.score);
    flags.no_child  = (lchild >= fill_x);
    flags.no_right  = (rchild >= fill_x);
    flags.stop      = (cur.score >= best.score);
    flags.full      = (fill == hpq_pkg::FILL_W'(hpq_pkg::CAPACITY));
    flags.empty     = (fill == '0);
  end

`ifndef ASSERT_OFF
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= hpq_pkg::FILL_W'(hpq_pkg::CAPACITY))
    else $error("fill count beyond capacity");
  a_fill_step: assert property (@(posedge clk) disable iff (rst)
    (cw.fill_op == hpq_pkg::FILL_DEC) |-> !flags.empty)
    else $error("remove from empty heap reached the datapath");
  a_write_inside: assert property (@(posedge clk) disable iff (rst)
    (we && cw.fill_op != hpq_pkg::FILL_INC) |->
      (hpq_pkg::FILL_W'(pos) <= fill))
    else $error("heap write beyond the filled region");
`endif

endmodule

@@ tb/sv/max_heap_priority_queue_top_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for max_heap_priority_queue_top: directed and random
// insert/remove traffic checked against a shadow heap kept inside the bench.
// Depends on hpq_pkg and the max_heap_priority_queue_top RTL.
module max_heap_priority_queue_top_tb;

  localparam int STALL_LIMIT = 4000;   // cycles with no transaction and no result
  localparam int DRAIN_CYCLES = 60;    // wait after the last expected result before the verdict
  localparam int SHOWN_FAULTS = 10;

  typedef struct {
    logic               func;
    logic signed [31:0] score;
    logic        [15:0] row;
    logic        [15:0] column;
  } heap_cmd_t;

  typedef struct {
    logic [1:0]                  status;
    logic                        top_valid;
    logic signed [31:0]          top_score;
    logic        [15:0]          top_row;
    logic        [15:0]          top_column;
    logic [hpq_pkg::COUNT_W-1:0] entry_count;
  } heap_view_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic func = hpq_pkg::FN_INSERT;
  logic signed [31:0] score = '0;
  logic [15:0] row = '0;
  logic [15:0] column = '0;
  logic busy;
  logic done;
  logic [1:0] status;
  logic top_valid;
  logic signed [31:0] top_score;
  logic [15:0] top_row;
  logic [15:0] top_column;
  logic [hpq_pkg::COUNT_W-1:0] entry_count;

  max_heap_priority_queue_top dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .func        (func),
    .score       (score),
    .row         (row),
    .column      (column),
    .done        (done),
    .status      (status),
    .top_valid   (top_valid),
    .top_score   (top_score),
    .top_row     (top_row),
    .top_column  (top_column),
    .entry_count (entry_count)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  heap_cmd_t  cmd_backlog[$];
  heap_view_t pending_views[$];
  int         fault_count = 0;
  int         idle_cycles = 0;
  int         plan_fill = 0;     // fill level the stimulus generator tracks
  logic       cmd_taken = 1'b0;

  // ---------------- shadow heap ----------------
  hpq_pkg::entry_t shadow_heap [hpq_pkg::CAPACITY];
  int unsigned     shadow_fill = 0;

  function automatic void swap_slots(int unsigned a, int unsigned b);
    hpq_pkg::entry_t t;
    t = shadow_heap[a];
    shadow_heap[a] = shadow_heap[b];
    shadow_heap[b] = t;
  endfunction

  // New entry climbs past parents with equal score.
  function automatic void climb(int unsigned pos);
    int unsigned parent;
    while (pos > 0) begin
      parent = (pos - 1) / 2;
      if ($signed(shadow_heap[parent].score) > $signed(shadow_heap[pos].score)) break;
      swap_slots(parent, pos);
      pos = parent;
    end
  endfunction

  // Right child wins only when strictly larger; stop when parent >= child.
  function automatic void sink(int unsigned pos);
    int unsigned kid;
    forever begin
      kid = 2 * pos + 1;
      if (kid >= shadow_fill) break;
      if (kid + 1 < shadow_fill &&
          $signed(shadow_heap[kid].score) < $signed(shadow_heap[kid + 1].score))
        kid++;
      if ($signed(shadow_heap[pos].score) >= $signed(shadow_heap[kid].score)) break;
      swap_slots(pos, kid);
      pos = kid;
    end
  endfunction

  function automatic heap_view_t apply_to_shadow(heap_cmd_t c);
    heap_view_t v;
    v.status = hpq_pkg::ST_DONE;
    if (c.func == hpq_pkg::FN_INSERT) begin
      if (shadow_fill >= hpq_pkg::CAPACITY) begin
        v.status = hpq_pkg::ST_FULL;
      end else begin
        shadow_heap[shadow_fill] = '{score: c.score, row: c.row, column: c.column};
        climb(shadow_fill);
        shadow_fill++;
      end
    end else begin
      if (shadow_fill == 0) begin
        v.status = hpq_pkg::ST_EMPTY;
      end else begin
        shadow_fill--;
        shadow_heap[0] = shadow_heap[shadow_fill];
        sink(0);
      end
    end
    if (shadow_fill > 0) begin
      v.top_valid  = 1'b1;
      v.top_score  = shadow_heap[0].score;
      v.top_row    = shadow_heap[0].row;
      v.top_column = shadow_heap[0].column;
    end else begin
      v.top_valid  = 1'b0;
      v.top_score  = '0;
      v.top_row    = '0;
      v.top_column = '0;
    end
    v.entry_count = hpq_pkg::COUNT_W'(shadow_fill);
    return v;
  endfunction

  function automatic void note_fault(string msg);
    fault_count++;
    if (fault_count <= SHOWN_FAULTS) $display("%0t: %s", $realtime, msg);
  endfunction

  // ---------------- monitor and checker ----------------
  always @(posedge clk) begin
    heap_view_t want;
    heap_cmd_t  seen;
    cmd_taken <= !rst && start && !busy;
    if (!rst) begin
      if (done) begin
        if (pending_views.size() == 0) begin
          note_fault("result strobe with no transaction outstanding");
        end else begin
          want = pending_views.pop_front();
          if (status !== want.status || top_valid !== want.top_valid ||
              top_score !== want.top_score || top_row !== want.top_row ||
              top_column !== want.top_column || entry_count !== want.entry_count)
            note_fault($sformatf({"result mismatch: exp st=%0d v=%0b sc=%0d r=%h c=%h n=%0d",
                                  " | got st=%0d v=%0b sc=%0d r=%h c=%h n=%0d"},
                                 want.status, want.top_valid, want.top_score,
                                 want.top_row, want.top_column, want.entry_count,
                                 status, top_valid, top_score, top_row, top_column,
                                 entry_count));
        end
      end
      if (start && !busy) begin
        seen = '{func: func, score: score, row: row, column: column};
        pending_views.push_back(apply_to_shadow(seen));
      end
    end
  end

  // ---------------- watchdog ----------------
  always @(posedge clk) begin
    if (!rst) begin
      if ((start && !busy) || done) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("[max_heap_priority_queue_top] ERROR");
        $finish;
      end
    end
  end

  // ---------------- driver: bursts separated by random gaps ----------------
  int        burst_left = 4;
  int        gap_left = 0;
  heap_cmd_t next_cmd;

  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || cmd_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (cmd_backlog.size() > 0) begin
        next_cmd = cmd_backlog.pop_front();
        func   <= next_cmd.func;
        score  <= next_cmd.score;
        row    <= next_cmd.row;
        column <= next_cmd.column;
        start  <= 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                   : $urandom_range(1, 12);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // ---------------- stimulus ----------------
  function automatic logic signed [31:0] pick_score();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 30) return $urandom;
    if (sel < 65) return $urandom_range(0, 6) - 3;   // narrow range: many ties
    if (sel < 80) begin
      case ($urandom_range(0, 3))
        0: return 32'sh7fffffff;
        1: return 32'sh80000000;
        2: return 32'sh0;
        default: return -32'sd1;
      endcase
    end
    return $urandom_range(0, 2000) - 1000;
  endfunction

  function automatic logic [15:0] pick_coord();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return 16'h0000;
    if (sel == 1) return 16'hffff;
    return 16'($urandom);
  endfunction

  task automatic push_insert(logic signed [31:0] s, logic [15:0] r, logic [15:0] c);
    cmd_backlog.push_back('{func: hpq_pkg::FN_INSERT, score: s, row: r, column: c});
    if (plan_fill < hpq_pkg::CAPACITY) plan_fill++;
  endtask

  // payload is junk on a remove; the block must ignore it
  task automatic push_remove();
    cmd_backlog.push_back('{func: hpq_pkg::FN_REMOVE, score: $urandom, row: 16'($urandom),
                            column: 16'($urandom)});
    if (plan_fill > 0) plan_fill--;
  endtask

  task automatic push_mixed(int count, int remove_pct);
    repeat (count) begin
      if ($urandom_range(0, 99) < remove_pct) push_remove();
      else push_insert(pick_score(), pick_coord(), pick_coord());
    end
  endtask

  initial begin
    // directed: empty remove, extremes, ties on insert and on child choice
    push_remove();
    push_insert(32'sd5, 16'd1, 16'd1);
    push_insert(32'sd5, 16'd2, 16'd2);            // equal score goes on top
    push_insert(32'sh7fffffff, 16'hffff, 16'hffff);
    push_insert(32'sh80000000, 16'h0000, 16'hffff);
    push_insert(32'sd0, 16'hffff, 16'h0000);
    push_insert(-32'sd1, 16'h5555, 16'haaaa);
    push_insert(32'sd5, 16'd3, 16'd3);
    repeat (8) push_remove();                     // drain past empty
    push_insert(32'sd10, 16'd10, 16'd10);
    push_insert(32'sd3, 16'hA, 16'hA);
    push_insert(32'sd3, 16'hB, 16'hB);
    push_insert(32'sd1, 16'd1, 16'd1);
    push_remove();                                // equal children: left wins
    push_remove();
    push_remove();
    push_remove();

    // random traffic, then fill to capacity and hammer the full boundary
    push_mixed(250, 40);
    while (plan_fill < hpq_pkg::CAPACITY) push_insert(pick_score(), pick_coord(), pick_coord());
    repeat (4) push_insert(pick_score(), pick_coord(), pick_coord());
    push_mixed(100, 50);
    push_mixed(250, 70);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    @(posedge clk);
    while (cmd_backlog.size() != 0 || start) @(posedge clk);
    @(negedge clk);
    while (pending_views.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fault_count == 0) begin
      $display("[max_heap_priority_queue_top] OK");
    end else begin
      $display("[max_heap_priority_queue_top] ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/hpq_pkg.sv
hw/rtl/hpq_ucode_rom.sv
hw/rtl/hpq_seq.sv
hw/rtl/hpq_datapath.sv
hw/rtl/max_heap_priority_queue_top.sv
tb/sv/max_heap_priority_queue_top_tb.sv
